FILE: rtl/mrm_pkg.sv
// Package for the max routing matrix: sizes, opcodes, state codes, and the
// queue entry type passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
package mrm_pkg;
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int HISTORY_DEPTH = 20;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int HW = $clog2(HISTORY_DEPTH);
	localparam int NW = $clog2(MAX_COLS + 1);
	localparam int VW = 17;
	localparam logic [VW-1:0] VALUE_MAX = 17'd65536;
	localparam int SNAP_WORDS = HISTORY_DEPTH * MAX_ROWS;
	localparam int SAW = $clog2(SNAP_WORDS);

	localparam logic [2:0] OP_DATA = 3'd0;
	localparam logic [2:0] OP_TOGGLE = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_IDENT = 3'd3;
	localparam logic [2:0] OP_UNDO = 3'd4;
	localparam logic [2:0] OP_COUNT = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIZE,
		ST_EMIT,
		ST_SNAP,
		ST_UNDO_RD,
		ST_UNDO_WR
	} back_state_t;

	// One command for the back end; data elements are absorbed by the front.
	typedef struct packed {
		logic [2:0] op;
		logic [RW-1:0] row;
		logic [CW-1:0] col;
		logic [4:0] count;
		logic [NW-1:0] length;
		logic ovf;
	} cmd_t;
endpackage

FILE: rtl/mrm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/mrm_front.sv
// Front end: stores vector elements, counts them, and queues commands.
// Depends on mrm_pkg.
`timescale 1ns / 1ps
module mrm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [2:0] opcode,
	input  logic [16:0] sample_value,
	input  logic last_element,
	input  logic [3:0] row_select,
	input  logic [3:0] col_select,
	input  logic [4:0] new_count,
	output logic q_push,
	output mrm_pkg::cmd_t q_cmd,
	input  logic q_full,
	output logic [mrm_pkg::VW-1:0] elem_q [mrm_pkg::MAX_COLS]
);
	logic [mrm_pkg::NW-1:0] count_q;
	logic trunc_q;
	logic take;
	logic is_data;
	logic [mrm_pkg::VW-1:0] sat;

	// Hold off while the queue is full; that alone does not stop elements overwriting a
	// vector being emitted, although the back end drains the queue entry only after emitting.
	assign full = q_full;
	assign take = push && !q_full;
	assign is_data = (opcode == mrm_pkg::OP_DATA);
	assign sat = (sample_value > mrm_pkg::VALUE_MAX) ? mrm_pkg::VALUE_MAX : sample_value;

	always_comb begin
		q_cmd.op = opcode;
		q_cmd.row = row_select[mrm_pkg::RW-1:0];
		q_cmd.col = col_select[mrm_pkg::CW-1:0];
		q_cmd.count = new_count;
		q_cmd.length = (count_q < mrm_pkg::NW'(mrm_pkg::MAX_COLS)) ? count_q + 1'b1 : count_q;
		q_cmd.ovf = trunc_q || (count_q == mrm_pkg::NW'(mrm_pkg::MAX_COLS));
		q_push = take && (!is_data || last_element);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			trunc_q <= 1'b0;
		end else if (take && is_data) begin
			if (last_element) begin
				count_q <= '0;
				trunc_q <= 1'b0;
			end else if (count_q < mrm_pkg::NW'(mrm_pkg::MAX_COLS)) begin
				count_q <= count_q + 1'b1;
			end else begin
				trunc_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_data && count_q < mrm_pkg::NW'(mrm_pkg::MAX_COLS)) begin
			elem_q[count_q[mrm_pkg::CW-1:0]] <= sat;
		end
	end
endmodule

FILE: rtl/mrm_queue.sv
// Short command queue between the front and back ends.
// Depends on mrm_pkg.
`timescale 1ns / 1ps
module mrm_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  mrm_pkg::cmd_t wdata,
	output logic q_full,
	input  logic rd,
	output logic q_empty,
	output mrm_pkg::cmd_t rdata
);
	mrm_pkg::cmd_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wdata;
	end
endmodule

FILE: rtl/mrm_back.sv
// Back end: owns the routing grid and the undo history, executes commands
// and emits one result per row. Depends on mrm_pkg and mrm_ram.
`timescale 1ns / 1ps
module mrm_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  mrm_pkg::cmd_t cmd,
	output logic q_pop,
	input  logic [mrm_pkg::VW-1:0] elem_q [mrm_pkg::MAX_COLS],
	output logic empty,
	input  logic pop,
	output logic [16:0] result_value,
	output logic [3:0] result_index,
	output logic final_result,
	output logic overflow_flag
);
	localparam int RC = mrm_pkg::RW + 1;

	mrm_pkg::back_state_t state_q, state_d;
	logic [mrm_pkg::MAX_COLS-1:0] grid_q [mrm_pkg::MAX_ROWS];
	logic [RC-1:0] rows_q;
	logic [mrm_pkg::NW-1:0] cols_q;
	logic [mrm_pkg::HW-1:0] head_q;
	logic [mrm_pkg::HW:0] fill_q;
	logic [mrm_pkg::RW-1:0] ptr_q;
	logic [mrm_pkg::HW-1:0] slot_q;
	logic out_v_q;

	logic [mrm_pkg::MAX_COLS-1:0] cmask;
	logic [mrm_pkg::VW-1:0] max_tree [2*mrm_pkg::MAX_COLS-1];
	logic [mrm_pkg::VW-1:0] best;
	logic last_row;
	logic [mrm_pkg::HW-1:0] head_inc, head_dec;
	logic [RC-1:0] new_rows;
	logic ram_we;
	logic [mrm_pkg::SAW-1:0] waddr, raddr;
	logic [mrm_pkg::MAX_COLS-1:0] rdata;
	logic emit_go;

	always_comb begin
		for (int j = 0; j < mrm_pkg::MAX_COLS; j++) begin
			cmask[j] = (j < int'(cols_q));
		end
	end

	// Max over the selected columns of the current row, as a balanced compare tree.
	always_comb begin
		for (int j = 0; j < mrm_pkg::MAX_COLS; j++) begin
			max_tree[mrm_pkg::MAX_COLS-1+j] = grid_q[ptr_q][j] ? elem_q[j] : '0;
		end
		for (int k = mrm_pkg::MAX_COLS - 2; k >= 0; k--) begin
			max_tree[k] = (max_tree[2*k+1] > max_tree[2*k+2]) ? max_tree[2*k+1] : max_tree[2*k+2];
		end
	end
	assign best = max_tree[0];

	assign last_row = ({1'b0, ptr_q} + 1'b1) == rows_q;
	assign head_inc = (head_q == mrm_pkg::HW'(mrm_pkg::HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? mrm_pkg::HW'(mrm_pkg::HISTORY_DEPTH - 1) : head_q - 1'b1;
	assign new_rows = (cmd.length > mrm_pkg::NW'(mrm_pkg::MAX_ROWS))
		? RC'(mrm_pkg::MAX_ROWS) : RC'(cmd.length);
	assign emit_go = !out_v_q || pop;

	assign ram_we = (state_q == mrm_pkg::ST_SNAP);
	assign waddr = mrm_pkg::SAW'(slot_q * mrm_pkg::MAX_ROWS + ptr_q);
	assign raddr = mrm_pkg::SAW'(head_dec * mrm_pkg::MAX_ROWS + ptr_q);

	mrm_ram #(.WIDTH(mrm_pkg::MAX_COLS), .DEPTH(mrm_pkg::SNAP_WORDS)) u_hist (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(grid_q[ptr_q]),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrm_pkg::ST_IDLE: begin
				if (!q_empty) begin
					unique case (cmd.op)
						mrm_pkg::OP_DATA:
							state_d = (cmd.length != cols_q) ? mrm_pkg::ST_SIZE : mrm_pkg::ST_EMIT;
						mrm_pkg::OP_TOGGLE:
							state_d = ({1'b0, cmd.row} < rows_q && {1'b0, cmd.col} < cols_q)
								? mrm_pkg::ST_SNAP : mrm_pkg::ST_IDLE;
						mrm_pkg::OP_CLEAR, mrm_pkg::OP_IDENT, mrm_pkg::OP_COUNT:
							state_d = mrm_pkg::ST_SNAP;
						mrm_pkg::OP_UNDO:
							state_d = (fill_q > 1) ? mrm_pkg::ST_UNDO_RD : mrm_pkg::ST_IDLE;
						default: state_d = mrm_pkg::ST_IDLE;
					endcase
				end
			end
			mrm_pkg::ST_SIZE: state_d = mrm_pkg::ST_SNAP;
			mrm_pkg::ST_SNAP:
				if (ptr_q == mrm_pkg::RW'(mrm_pkg::MAX_ROWS - 1))
					state_d = (cmd.op == mrm_pkg::OP_DATA) ? mrm_pkg::ST_EMIT : mrm_pkg::ST_IDLE;
			mrm_pkg::ST_EMIT:
				if (emit_go && last_row) state_d = mrm_pkg::ST_IDLE;
			mrm_pkg::ST_UNDO_RD: state_d = mrm_pkg::ST_UNDO_WR;
			mrm_pkg::ST_UNDO_WR:
				state_d = (ptr_q == mrm_pkg::RW'(mrm_pkg::MAX_ROWS - 1))
					? mrm_pkg::ST_IDLE : mrm_pkg::ST_UNDO_RD;
			default: state_d = mrm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		unique case (state_q)
			mrm_pkg::ST_IDLE:
				q_pop = !q_empty && state_d == mrm_pkg::ST_IDLE;
			mrm_pkg::ST_SNAP:
				q_pop = state_d == mrm_pkg::ST_IDLE;
			mrm_pkg::ST_EMIT:
				q_pop = state_d == mrm_pkg::ST_IDLE;
			mrm_pkg::ST_UNDO_WR:
				q_pop = state_d == mrm_pkg::ST_IDLE;
			default: q_pop = 1'b0;
		endcase
	end

	assign empty = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrm_pkg::ST_IDLE;
			rows_q <= RC'(10 > mrm_pkg::MAX_ROWS ? mrm_pkg::MAX_ROWS : 10);
			cols_q <= '0;
			head_q <= '0;
			fill_q <= '0;
			ptr_q <= '0;
			slot_q <= '0;
			out_v_q <= 1'b0;
			result_value <= '0;
			result_index <= '0;
			final_result <= 1'b0;
			overflow_flag <= 1'b0;
			for (int i = 0; i < mrm_pkg::MAX_ROWS; i++) grid_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mrm_pkg::ST_EMIT && emit_go) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			unique case (state_q)
				mrm_pkg::ST_IDLE: begin
					ptr_q <= '0;
					slot_q <= (fill_q != 0) ? head_inc : head_q;
					if (!q_empty) begin
						unique case (cmd.op)
							mrm_pkg::OP_TOGGLE:
								if ({1'b0, cmd.row} < rows_q && {1'b0, cmd.col} < cols_q)
									grid_q[cmd.row][cmd.col] <= ~grid_q[cmd.row][cmd.col];
							mrm_pkg::OP_CLEAR:
								for (int i = 0; i < mrm_pkg::MAX_ROWS; i++) grid_q[i] <= '0;
							mrm_pkg::OP_IDENT:
								for (int i = 0; i < mrm_pkg::MAX_ROWS; i++)
									grid_q[i] <= (i < int'(rows_q) && i < int'(cols_q))
										? mrm_pkg::MAX_COLS'(1) << i : '0;
							mrm_pkg::OP_COUNT: begin
								logic [RC-1:0] f;
								f = (cmd.count == 0) ? RC'(1)
									: (cmd.count > 5'(mrm_pkg::MAX_ROWS)) ? RC'(mrm_pkg::MAX_ROWS)
									: RC'(cmd.count);
								rows_q <= f;
								for (int i = 0; i < mrm_pkg::MAX_ROWS; i++)
									if (i >= int'(f)) grid_q[i] <= '0;
							end
							mrm_pkg::OP_DATA:
								if (cmd.length != cols_q) begin
									cols_q <= cmd.length;
									rows_q <= new_rows;
								end
							default: ;
						endcase
					end
				end
				mrm_pkg::ST_SIZE:
					for (int i = 0; i < mrm_pkg::MAX_ROWS; i++)
						grid_q[i] <= (i < int'(rows_q) && i < int'(cols_q))
							? mrm_pkg::MAX_COLS'(1) << i : '0;
				mrm_pkg::ST_SNAP: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == mrm_pkg::RW'(mrm_pkg::MAX_ROWS - 1)) begin
						head_q <= slot_q;
						if (fill_q < (mrm_pkg::HW + 1)'(mrm_pkg::HISTORY_DEPTH))
							fill_q <= fill_q + 1'b1;
						ptr_q <= '0;
					end
				end
				mrm_pkg::ST_EMIT:
					if (emit_go) begin
						result_value <= best;
						result_index <= 4'(ptr_q);
						final_result <= last_row;
						overflow_flag <= cmd.ovf;
						ptr_q <= ptr_q + 1'b1;
					end
				mrm_pkg::ST_UNDO_RD: ;
				mrm_pkg::ST_UNDO_WR: begin
					grid_q[ptr_q] <= ({1'b0, ptr_q} < rows_q) ? (rdata & cmask) : '0;
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == mrm_pkg::RW'(mrm_pkg::MAX_ROWS - 1)) begin
						head_q <= head_dec;
						fill_q <= fill_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (mrm_pkg::HW + 1)'(mrm_pkg::HISTORY_DEPTH))
		else $error("history fill beyond depth");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !pop |=> out_v_q && $stable(result_index))
		else $error("pending result changed");
	a_pop_state: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mrm_pkg::ST_EMIT && emit_go && last_row |=> state_q == mrm_pkg::ST_IDLE)
		else $error("emit did not end after last row");
endmodule

FILE: rtl/max_routing_matrix_unit.sv
// Max routing matrix: data elements transfer one per cycle while full is low. A
// completing element queues a data command; the back end dispatches it, on a length
// change resizes and snapshots the grid, then emits one result per row, one per cycle
// while the consumer pops. Edits snapshot the grid; undo reads and writes each row.
// arst_n clears the grid and history pointers and resets the counts; history RAM and
// element store come up undefined and are only read after being written.
`timescale 1ns / 1ps
module max_routing_matrix_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [2:0] opcode,
	input  logic [16:0] sample_value,
	input  logic last_element,
	input  logic [3:0] row_select,
	input  logic [3:0] col_select,
	input  logic [4:0] new_count,
	output logic empty,
	input  logic pop,
	output logic [16:0] result_value,
	output logic [3:0] result_index,
	output logic final_result,
	output logic overflow_flag
);
	mrm_pkg::cmd_t fq_cmd, bq_cmd;
	logic fq_push, q_full, q_empty, q_pop;
	logic [mrm_pkg::VW-1:0] elem [mrm_pkg::MAX_COLS];
	logic front_full;

	// Stall the front while the queue head is a vector command, so new elements
	// cannot overwrite the element store while the back end reads that vector.
	logic busy_vec;
	assign busy_vec = !q_empty && bq_cmd.op == mrm_pkg::OP_DATA;

	mrm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push && !busy_vec), .full(front_full),
		.opcode(opcode), .sample_value(sample_value), .last_element(last_element),
		.row_select(row_select), .col_select(col_select), .new_count(new_count),
		.q_push(fq_push), .q_cmd(fq_cmd), .q_full(q_full), .elem_q(elem)
	);
	assign full = front_full || busy_vec;

	mrm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(fq_push), .wdata(fq_cmd), .q_full(q_full),
		.rd(q_pop), .q_empty(q_empty), .rdata(bq_cmd)
	);

	mrm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .cmd(bq_cmd), .q_pop(q_pop),
		.elem_q(elem), .empty(empty), .pop(pop), .result_value(result_value),
		.result_index(result_index), .final_result(final_result),
		.overflow_flag(overflow_flag)
	);
endmodule
